>>> hw/rtl/rau_pkg.sv
`timescale 1ns / 1ps

package rau_pkg;

    // Default operand width; fields on the ports are always 32 bits wide
    localparam int DATA_WIDTH_DEF = 32;

    // Port field geometry
    localparam int FIELD_W     = 32;
    localparam int DEN_OUT_W   = 31;
    localparam int S_TDATA_W   = 4 * FIELD_W;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 64;
    localparam int M_TUSER_W   = 2;

    // Operation codes carried in the input tuser
    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } t_kind;

    // Multiplier operand pairs
    typedef enum logic [2:0] {
        MS_AN_BQ,
        MS_BN_AQ,
        MS_AD_BQ,
        MS_AN_BN,
        MS_AD_BD,
        MS_AN_BD,
        MS_AD_BN
    } t_msel;

    // Multiplier destination register
    typedef enum logic [1:0] {
        MD_P1,
        MD_P2,
        MD_DN
    } t_mdst;

    // Operand source for the gcd and divider units
    typedef enum logic {
        SRC_IN,
        SRC_RES
    } t_src;

    // Controller to datapath
    typedef struct packed {
        logic  load;
        logic  gcd_init;
        t_src  gcd_src;
        logic  gcd_step;
        logic  gcd_fin;
        logic  div_init;
        t_src  div_src;
        logic  div_step;
        logic  mul_en;
        t_msel mul_sel;
        t_mdst mul_dst;
        logic  add_en;
        logic  wb_en;
        logic  out_wr;
        logic  out_inv;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_kind kind;
        logic  in_zero;
        logic  gcd_done;
        logic  num_zero;
        logic  den_zero;
    } t_status;

endpackage

>>> hw/rtl/rau_dp.sv
`timescale 1ns / 1ps

module rau_dp #(
    parameter int DATA_WIDTH = rau_pkg::DATA_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  rau_pkg::t_cmd              i_cmd,
    input  logic [rau_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic [rau_pkg::S_TUSER_W-1:0] i_s_tuser,
    output rau_pkg::t_status           o_st,
    output logic [rau_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic [rau_pkg::M_TUSER_W-1:0] o_m_tuser
);
    import rau_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int PW = 2 * DATA_WIDTH;
    localparam int KW = $clog2(PW);
    localparam int OW = (PW > FIELD_W) ? PW : FIELD_W;
    localparam logic [PW-1:0] HALF = PW'(1) << (DW - 1);

    // Operand registers, sign and magnitude
    t_kind          r_kind;
    logic [DW-1:0]  r_an, r_ad, r_bn, r_bd;
    logic           r_an_s, r_ad_s, r_bn_s, r_bd_s;

    // Product / result registers
    logic [PW-1:0]  r_p1, r_p2, r_dn;
    logic           r_p1_s, r_p2_s, r_dn_s;

    // Binary gcd unit
    logic [PW-1:0]  r_gx, r_gy, r_g;
    logic [KW-1:0]  r_gk;

    // Two-lane restoring divider sharing the divisor r_g
    logic [PW-1:0]  r_dq [2];
    logic [PW-1:0]  r_dr [2];

    // Output register
    logic [FIELD_W-1:0]   r_res_num;
    logic [DEN_OUT_W-1:0] r_res_den;
    logic                 r_res_ok, r_ovf;

    // Field unpacking: low DW bits, split into the sign at bit DW-1 and the magnitude
    logic [DW-1:0] f_mag [4];
    logic          f_neg [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            f_neg[k] = i_s_tdata[FIELD_W*k + DW - 1];
            f_mag[k] = f_neg[k] ? DW'(-i_s_tdata[FIELD_W*k +: DW]) : i_s_tdata[FIELD_W*k +: DW];
        end
    end

    // Multiplier operand selection
    logic [DW-1:0] mul_a, mul_b;
    logic          mul_s, sb2;
    logic [PW-1:0] mul_p;

    assign sb2 = r_bn_s ^ (r_kind == KIND_SUB);

    always_comb begin
        case (i_cmd.mul_sel)
            MS_AN_BQ: begin mul_a = r_an; mul_b = r_dq[1][DW-1:0]; mul_s = r_an_s ^ r_bd_s; end
            MS_BN_AQ: begin mul_a = r_bn; mul_b = r_dq[0][DW-1:0]; mul_s = sb2 ^ r_ad_s;    end
            MS_AD_BQ: begin mul_a = r_ad; mul_b = r_dq[1][DW-1:0]; mul_s = r_ad_s ^ r_bd_s; end
            MS_AN_BN: begin mul_a = r_an; mul_b = r_bn;            mul_s = r_an_s ^ r_bn_s; end
            MS_AD_BD: begin mul_a = r_ad; mul_b = r_bd;            mul_s = r_ad_s ^ r_bd_s; end
            MS_AN_BD: begin mul_a = r_an; mul_b = r_bd;            mul_s = r_an_s ^ r_bd_s; end
            MS_AD_BN: begin mul_a = r_ad; mul_b = r_bn;            mul_s = r_ad_s ^ r_bn_s; end
            default:  begin mul_a = '0;   mul_b = '0;              mul_s = 1'b0;            end
        endcase
        mul_p = PW'(mul_a) * PW'(mul_b);
    end

    // Signed-magnitude add of the two numerator terms
    logic [PW-1:0] add_m;
    logic          add_s;

    always_comb begin
        if (r_p1_s == r_p2_s) begin
            add_m = r_p1 + r_p2;
            add_s = r_p1_s;
        end else if (r_p1 >= r_p2) begin
            add_m = r_p1 - r_p2;
            add_s = r_p1_s;
        end else begin
            add_m = r_p2 - r_p1;
            add_s = r_p2_s;
        end
    end

    // One binary gcd step
    logic [PW-1:0] gx_n, gy_n;
    logic [KW-1:0] gk_n;

    always_comb begin
        gx_n = r_gx;
        gy_n = r_gy;
        gk_n = r_gk;
        if (!r_gx[0] && !r_gy[0]) begin
            gx_n = r_gx >> 1;
            gy_n = r_gy >> 1;
            gk_n = r_gk + KW'(1);
        end else if (!r_gx[0]) begin
            gx_n = r_gx >> 1;
        end else if (!r_gy[0]) begin
            gy_n = r_gy >> 1;
        end else if (r_gx >= r_gy) begin
            gx_n = (r_gx - r_gy) >> 1;
        end else begin
            gy_n = (r_gy - r_gx) >> 1;
        end
    end

    // One quotient bit per lane
    logic [PW:0]   dv_t  [2];
    logic [PW:0]   dv_t2 [2];
    logic          dv_ge [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            dv_t[l]  = {r_dr[l], r_dq[l][PW-1]};
            dv_ge[l] = dv_t[l] >= {1'b0, r_g};
            dv_t2[l] = dv_ge[l] ? (dv_t[l] - {1'b0, r_g}) : dv_t[l];
        end
    end

    // Final sign, overflow and two's-complement numerator
    logic          fin_neg, fin_ovf;
    logic [OW-1:0] fin_num, fin_den;

    always_comb begin
        fin_neg = (r_p1 != '0) && (r_p1_s != r_dn_s);
        fin_ovf = (r_p1 > (fin_neg ? HALF : HALF - PW'(1))) || (r_dn > HALF - PW'(1));
        fin_num = fin_neg ? -OW'(r_p1) : OW'(r_p1);
        fin_den = OW'(r_dn);
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= t_kind'(i_s_tuser);
            r_an   <= f_mag[0];  r_an_s <= f_neg[0];
            r_ad   <= f_mag[1];  r_ad_s <= f_neg[1];
            r_bn   <= f_mag[2];  r_bn_s <= f_neg[2];
            r_bd   <= f_mag[3];  r_bd_s <= f_neg[3];
        end

        if (i_cmd.mul_en) begin
            case (i_cmd.mul_dst)
                MD_P1:   begin r_p1 <= mul_p; r_p1_s <= mul_s; end
                MD_P2:   begin r_p2 <= mul_p; r_p2_s <= mul_s; end
                MD_DN:   begin r_dn <= mul_p; r_dn_s <= mul_s; end
                default: ;
            endcase
        end else if (i_cmd.add_en) begin
            r_p1   <= add_m;
            r_p1_s <= add_s;
        end else if (i_cmd.wb_en) begin
            r_p1 <= r_dq[0];
            r_dn <= r_dq[1];
        end

        if (i_cmd.gcd_init) begin
            r_gx <= (i_cmd.gcd_src == SRC_IN) ? PW'(r_ad) : r_p1;
            r_gy <= (i_cmd.gcd_src == SRC_IN) ? PW'(r_bd) : r_dn;
            r_gk <= '0;
        end else if (i_cmd.gcd_step) begin
            r_gx <= gx_n;
            r_gy <= gy_n;
            r_gk <= gk_n;
        end

        if (i_cmd.gcd_fin) begin
            r_g <= (r_gx | r_gy) << r_gk;
        end

        if (i_cmd.div_init) begin
            r_dq[0] <= (i_cmd.div_src == SRC_IN) ? PW'(r_ad) : r_p1;
            r_dq[1] <= (i_cmd.div_src == SRC_IN) ? PW'(r_bd) : r_dn;
            r_dr[0] <= '0;
            r_dr[1] <= '0;
        end else if (i_cmd.div_step) begin
            for (int l = 0; l < 2; l++) begin
                r_dr[l] <= dv_t2[l][PW-1:0];
                r_dq[l] <= {r_dq[l][PW-2:0], dv_ge[l]};
            end
        end

        if (i_cmd.out_wr) begin
            if (i_cmd.out_inv) begin
                r_res_num <= '0;
                r_res_den <= '0;
                r_res_ok  <= 1'b0;
                r_ovf     <= 1'b0;
            end else begin
                r_res_num <= fin_num[FIELD_W-1:0];
                r_res_den <= fin_den[DEN_OUT_W-1:0];
                r_res_ok  <= 1'b1;
                r_ovf     <= fin_ovf;
            end
        end
    end

    // Status back to the controller
    assign o_st.kind     = r_kind;
    assign o_st.in_zero  = (r_ad == '0) || (r_bd == '0);
    assign o_st.gcd_done = (r_gx == '0) || (r_gy == '0);
    assign o_st.num_zero = (r_p1 == '0);
    assign o_st.den_zero = (r_dn == '0);

    assign o_m_tdata = {{(M_TDATA_W - FIELD_W - DEN_OUT_W){1'b0}}, r_res_den, r_res_num};
    assign o_m_tuser = {r_ovf, r_res_ok};

endmodule

>>> hw/rtl/rau_ctrl.sv
`timescale 1ns / 1ps

module rau_ctrl #(
    parameter int DATA_WIDTH = rau_pkg::DATA_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic              i_m_tready,
    output logic              o_m_tvalid,
    input  rau_pkg::t_status  i_st,
    output rau_pkg::t_cmd     o_cmd
);
    import rau_pkg::*;

    localparam int PW = 2 * DATA_WIDTH;
    localparam int CW = $clog2(PW);

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_G1_INIT,
        S_G1_STEP,
        S_G1_FIN,
        S_D1_INIT,
        S_D1_STEP,
        S_M1,
        S_M2,
        S_M3,
        S_ADD,
        S_MUL_A,
        S_MUL_B,
        S_TEST,
        S_G2_INIT,
        S_G2_STEP,
        S_G2_FIN,
        S_D2_INIT,
        S_D2_STEP,
        S_WB,
        S_EMIT,
        S_EMIT_INV
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_m_tvalid, n_m_tvalid;
    logic          out_free;
    logic          is_mul;
    t_cmd          cmd;

    assign out_free = !r_m_tvalid || i_m_tready;
    assign is_mul   = (i_st.kind == KIND_MUL);

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                cmd.load = i_s_tvalid;
                if (i_s_tvalid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_st.in_zero) begin
                    n_state = S_EMIT_INV;
                end else if (i_st.kind == KIND_ADD || i_st.kind == KIND_SUB) begin
                    n_state = S_G1_INIT;
                end else begin
                    n_state = S_MUL_A;
                end
            end
            S_G1_INIT: begin
                cmd.gcd_init = 1'b1;
                cmd.gcd_src  = SRC_IN;
                n_state      = S_G1_STEP;
            end
            S_G1_STEP: begin
                cmd.gcd_step = !i_st.gcd_done;
                if (i_st.gcd_done) n_state = S_G1_FIN;
            end
            S_G1_FIN: begin
                cmd.gcd_fin = 1'b1;
                n_state     = S_D1_INIT;
            end
            S_D1_INIT: begin
                cmd.div_init = 1'b1;
                cmd.div_src  = SRC_IN;
                n_cnt        = '0;
                n_state      = S_D1_STEP;
            end
            S_D1_STEP: begin
                cmd.div_step = 1'b1;
                n_cnt        = r_cnt + CW'(1);
                if (r_cnt == CW'(PW - 1)) n_state = S_M1;
            end
            S_M1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_AN_BQ;
                cmd.mul_dst = MD_P1;
                n_state     = S_M2;
            end
            S_M2: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_BN_AQ;
                cmd.mul_dst = MD_P2;
                n_state     = S_M3;
            end
            S_M3: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_AD_BQ;
                cmd.mul_dst = MD_DN;
                n_state     = S_ADD;
            end
            S_ADD: begin
                cmd.add_en = 1'b1;
                n_state    = S_TEST;
            end
            S_MUL_A: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = is_mul ? MS_AN_BN : MS_AN_BD;
                cmd.mul_dst = MD_P1;
                n_state     = S_MUL_B;
            end
            S_MUL_B: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = is_mul ? MS_AD_BD : MS_AD_BN;
                cmd.mul_dst = MD_DN;
                n_state     = S_TEST;
            end
            S_TEST: begin
                if (i_st.den_zero) begin
                    n_state = S_EMIT_INV;
                end else if (i_st.num_zero) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_G2_INIT;
                end
            end
            S_G2_INIT: begin
                cmd.gcd_init = 1'b1;
                cmd.gcd_src  = SRC_RES;
                n_state      = S_G2_STEP;
            end
            S_G2_STEP: begin
                cmd.gcd_step = !i_st.gcd_done;
                if (i_st.gcd_done) n_state = S_G2_FIN;
            end
            S_G2_FIN: begin
                cmd.gcd_fin = 1'b1;
                n_state     = S_D2_INIT;
            end
            S_D2_INIT: begin
                cmd.div_init = 1'b1;
                cmd.div_src  = SRC_RES;
                n_cnt        = '0;
                n_state      = S_D2_STEP;
            end
            S_D2_STEP: begin
                cmd.div_step = 1'b1;
                n_cnt        = r_cnt + CW'(1);
                if (r_cnt == CW'(PW - 1)) n_state = S_WB;
            end
            S_WB: begin
                cmd.wb_en = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                cmd.out_wr = out_free;
                if (out_free) n_state = S_IDLE;
            end
            S_EMIT_INV: begin
                cmd.out_wr  = out_free;
                cmd.out_inv = 1'b1;
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        // Output register valid: loaded on write, cleared on transfer
        if (cmd.out_wr) begin
            n_m_tvalid = 1'b1;
        end else if (i_m_tready) begin
            n_m_tvalid = 1'b0;
        end else begin
            n_m_tvalid = r_m_tvalid;
        end
    end

    // State, counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_tvalid;
    assign o_cmd      = cmd;

    // A result is never written over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_wr |-> (!r_m_tvalid || i_m_tready))
        else $error("result register overwritten");

    // An accepted item starts operand checking next cycle
    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_CHECK))
        else $error("accepted item not checked");

    // gcd never steps past termination
    a_gcd_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.gcd_step |-> !i_st.gcd_done)
        else $error("gcd stepped after completion");

    // A write of the result register always raises the output valid
    a_valid_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_wr |=> r_m_tvalid)
        else $error("result written but not presented");

endmodule

>>> hw/rtl/rational_arith_unit.sv
`timescale 1ns / 1ps

// Rational arithmetic unit: one signed fraction result per operand pair.
// Input channel (s): tuser carries the operation (add, sub, mul, div);
//   tdata carries a_num, a_den, b_num, b_den, 32 bits each.
// Output channel (m): tdata carries the reduced numerator and the positive
//   denominator; tuser carries the valid flag and the overflow flag.
// One item is worked at a time. A zero denominator operand, or a zero
//   product denominator, gives an invalid result. Multiply and divide form
//   the two products and reduce them; add and subtract first divide the
//   denominators by their gcd, then form three products and the sum and
//   reduce it (a zero numerator skips the reduction). G1 and G2 are the
//   binary gcd steps, one per cycle and at most the combined bit count of
//   the two gcd operands (2*DATA_WIDTH for the denominators, 4*DATA_WIDTH
//   for the product pair). Each exact division runs 2*DATA_WIDTH quotient
//   steps on a two-lane restoring divider. The next item is taken in the
//   cycle after the result is written.
// The result sits in an output register; the next item is taken while it
//   waits. If the receiver stalls, the following result holds in the
//   datapath until the register frees.
// Synchronous active-low reset returns the sequencer to idle and drops
//   output valid; no memory needs clearing.
module rational_arith_unit #(
    parameter int DATA_WIDTH = rau_pkg::DATA_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [31:0] a_num, [63:32] a_den, [95:64] b_num, [127:96] b_den
    input  logic [rau_pkg::S_TDATA_W-1:0] i_s_tdata,
    // [1:0] kind
    input  logic [rau_pkg::S_TUSER_W-1:0] i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [31:0] res_num, [62:32] res_den, [63] zero
    output logic [rau_pkg::M_TDATA_W-1:0] o_m_tdata,
    // [0] res_valid, [1] overflow
    output logic [rau_pkg::M_TUSER_W-1:0] o_m_tuser
);
    import rau_pkg::*;

    t_cmd    cmd;
    t_status st;

    rau_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    rau_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_cmd     (cmd),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_st      (st),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

endmodule
